### sv/aitml_pkg.sv
// Shared types and constants for the application id table merge and lookup unit.
`default_nettype none

package aitml_pkg;

   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 40;

   typedef enum logic {
      ACT_MERGE = 1'b0,
      ACT_CHECK = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic [31:0] app;
      logic [31:0] vendor;
      logic        auth;
      logic        acct;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

### sv/aitml_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module aitml_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### sv/aitml_ctrl.sv
// Sequencer: accept a beat, scan the table, commit the result.
`default_nettype none

module aitml_ctrl
   import aitml_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### sv/aitml_dp.sv
// Datapath: item registers, fill count, table scan and result register.
`default_nettype none

module aitml_dp
   import aitml_pkg::*;
#(
   parameter int TABLE_DEPTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tuser,
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire cmd_type               cmd,
   output status_type                 status
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   action_type  item_action_ff, item_action_in;
   entry_type   item_ff, item_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] addr_ff, addr_in;
   logic        pend_ff, pend_in;
   logic [AW-1:0] pend_idx_ff, pend_idx_in;
   logic        hit_ff, hit_in;
   logic [AW-1:0] slot_ff, slot_in;
   entry_type   hit_entry_ff, hit_entry_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic        wr_en;
   logic [AW-1:0] wr_addr;
   entry_type   wr_data;
   logic        rd_en;
   entry_type   rd_data;
   logic        full;
   logic        out_found;
   entry_type   out_entry;
   logic        out_full;

   aitml_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (addr_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   assign full              = (count_ff == CW'(TABLE_DEPTH));
   assign rd_en             = cmd.scan && !hit_ff && (addr_ff != count_ff);
   assign status.scan_done  = !pend_ff && (hit_ff || (addr_ff == count_ff));
   assign status.out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid        = rsp_valid_ff;
   assign rsp_tdata         = rsp_data_ff;

   always_comb begin
      item_action_in = item_action_ff;
      item_in        = item_ff;
      count_in       = count_ff;
      addr_in        = addr_ff;
      pend_in        = pend_ff;
      pend_idx_in    = pend_idx_ff;
      hit_in         = hit_ff;
      slot_in        = slot_ff;
      hit_entry_in   = hit_entry_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      wr_en          = 1'b0;
      wr_addr        = count_ff[AW-1:0];
      wr_data        = item_ff;
      out_found      = hit_ff;
      out_entry      = '0;
      out_full       = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.load) begin
         item_action_in = action_type'(req_tuser);
         item_in.app    = req_tdata[31:0];
         item_in.vendor = req_tdata[63:32];
         item_in.auth   = req_tdata[64];
         item_in.acct   = req_tdata[65];
         addr_in        = '0;
         pend_in        = 1'b0;
         hit_in         = 1'b0;
      end

      if (cmd.scan) begin
         pend_in     = rd_en;
         pend_idx_in = addr_ff[AW-1:0];
         if (rd_en) begin
            addr_in = addr_ff + CW'(1);
         end
         if (pend_ff && !hit_ff && (rd_data.app == item_ff.app)) begin
            hit_in       = 1'b1;
            slot_in      = pend_idx_ff;
            hit_entry_in = rd_data;
         end
      end

      if (cmd.commit) begin
         if (item_action_ff == ACT_CHECK) begin
            if (hit_ff) begin
               out_entry = hit_entry_ff;
            end
         end else if (hit_ff) begin
            out_entry      = hit_entry_ff;
            out_entry.auth = hit_entry_ff.auth | item_ff.auth;
            out_entry.acct = hit_entry_ff.acct | item_ff.acct;
            wr_en          = 1'b1;
            wr_addr        = slot_ff;
            wr_data        = out_entry;
         end else if (!full) begin
            out_entry = item_ff;
            wr_en     = 1'b1;
            wr_addr   = count_ff[AW-1:0];
            wr_data   = item_ff;
            count_in  = count_ff + CW'(1);
         end else begin
            out_full = 1'b1;
         end
         rsp_valid_in = 1'b1;
         rsp_data_in  = {4'b0000, out_full, out_entry.acct, out_entry.auth,
                         out_entry.vendor, out_found};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         addr_ff      <= '0;
         pend_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         addr_ff      <= addr_in;
         pend_ff      <= pend_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_action_ff <= item_action_in;
      item_ff        <= item_in;
      pend_idx_ff    <= pend_idx_in;
      slot_ff        <= slot_in;
      hit_entry_ff   <= hit_entry_in;
      rsp_data_ff    <= rsp_data_in;
   end

endmodule

`default_nettype wire

### sv/app_id_table_merge_lookup_unit.sv
// Top level of the application id table merge and lookup unit.
//
// The table holds up to TABLE_DEPTH entries of application id, vendor id and the
// authentication and accounting flags; entries are filled in order and never
// removed, so a fill count stands for the valid bits and reset empties the table
// at once. Each beat scans the filled entries one per cycle through the table
// RAM's single read port and stops early on a match; a new beat is accepted
// only after the result of the last one is committed. The result register
// decouples the two sides; the result is written only once that register is
// free.
`default_nettype none

module app_id_table_merge_lookup_unit
   import aitml_pkg::*;
#(
   parameter int TABLE_DEPTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // app_id[31:0], vendor_id[63:32], want_auth[64], want_acct[65], zero[71:66]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // action[0]
   input  wire logic                  req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // found[0], found_vendor[32:1], found_auth[33], found_acct[34],
   // table_full[35], zero[39:36]
   output logic      [RSP_DATA_W-1:0] rsp_tdata
);

   cmd_type    cmd;
   status_type status;

   aitml_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   aitml_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

`default_nettype wire

### sv/aitml_checker.sv
// Port-level checks for the application id table unit, bound to the top level.
`default_nettype none

module aitml_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat dropped or changed while stalled");

   a_full_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[35] |-> rsp_tdata[34:0] == 35'd0)
      else $error("full result carries entry data");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second beat taken while an item is in progress");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind app_id_table_merge_lookup_unit aitml_checker u_aitml_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

### test/testbench.sv
// Self-checking testbench for the application id table merge and lookup unit.
`default_nettype none

module testbench
   import aitml_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 32;
   localparam int POOL_SIZE = 40;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic        found;
      logic [31:0] vendor;
      logic        auth;
      logic        acct;
      logic        full;
   } lookup_rsp_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   logic        tbl_valid  [DEPTH];
   logic [31:0] tbl_app    [DEPTH];
   logic [31:0] tbl_vendor [DEPTH];
   logic        tbl_auth   [DEPTH];
   logic        tbl_acct   [DEPTH];

   lookup_rsp_type pending_rsp[$];
   logic [31:0] id_pool[POOL_SIZE];
   int          mismatch_count = 0;
   bit          no_idle = 0;
   bit          hold_rsp = 0;

   app_id_table_merge_lookup_unit #(
      .TABLE_DEPTH(DEPTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      rsp_tready = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic lookup_rsp_type merge_or_lookup(action_type act, logic [31:0] id,
                                                      logic [31:0] vendor, logic auth,
                                                      logic acct);
      int             hit;
      int             slot;
      lookup_rsp_type r;
      hit = -1;
      for (int i = 0; i < DEPTH; i++) begin
         if (hit < 0 && tbl_valid[i] && tbl_app[i] == id) begin
            hit = i;
         end
      end
      r = '0;
      r.found = (hit >= 0);
      slot = hit;
      if (act == ACT_MERGE) begin
         if (hit >= 0) begin
            tbl_auth[hit] = tbl_auth[hit] | auth;
            tbl_acct[hit] = tbl_acct[hit] | acct;
         end else begin
            for (int i = DEPTH - 1; i >= 0; i--) begin
               if (!tbl_valid[i]) begin
                  slot = i;
               end
            end
            if (slot >= 0) begin
               tbl_valid[slot] = 1'b1;
               tbl_app[slot] = id;
               tbl_vendor[slot] = vendor;
               tbl_auth[slot] = auth;
               tbl_acct[slot] = acct;
            end else begin
               r.full = 1'b1;
            end
         end
      end
      if (slot >= 0) begin
         r.vendor = tbl_vendor[slot];
         r.auth = tbl_auth[slot];
         r.acct = tbl_acct[slot];
      end
      return r;
   endfunction

   task automatic send_item(action_type act, logic [31:0] id, logic [31:0] vendor,
                            logic auth, logic acct);
      @(negedge clock);
      if (!no_idle && $urandom_range(99) < 27) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {6'b0, acct, auth, vendor, id};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_rsp.push_back(merge_or_lookup(act, id, vendor, auth, acct));
   endtask

   task automatic send_random_item();
      logic [31:0] id;
      action_type  act;
      int          pick;
      pick = $urandom_range(99);
      if (pick < 85) begin
         id = id_pool[$urandom_range(POOL_SIZE - 1)];
      end else begin
         id = $urandom;
      end
      act = ($urandom_range(99) < 35) ? ACT_CHECK : ACT_MERGE;
      send_item(act, id, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)));
   endtask

   // rsp_tready: random stalls, or a counted hold-off when requested
   initial begin
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 0;
         end else begin
            rsp_tready <= no_idle || ($urandom_range(99) >= 27);
         end
      end
   end

   initial begin
      lookup_rsp_type got;
      lookup_rsp_type exp;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.found = rsp_tdata[0];
            got.vendor = rsp_tdata[32:1];
            got.auth = rsp_tdata[33];
            got.acct = rsp_tdata[34];
            got.full = rsp_tdata[35];
            if (pending_rsp.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: unexpected result beat %h", $realtime, rsp_tdata);
               end
            end else begin
               exp = pending_rsp.pop_front();
               if (got.found !== exp.found || got.vendor !== exp.vendor ||
                   got.auth !== exp.auth || got.acct !== exp.acct ||
                   got.full !== exp.full) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%0t: found %b/%b vendor %h/%h auth %b/%b acct %b/%b full %b/%b",
                              $realtime, exp.found, got.found, exp.vendor, got.vendor,
                              exp.auth, got.auth, exp.acct, got.acct, exp.full, got.full);
                  end
               end
            end
         end
      end
   end

   task automatic test_empty_lookup();
      send_item(ACT_CHECK, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1);
      send_item(ACT_CHECK, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0);
   endtask

   task automatic test_insert_and_merge();
      send_item(ACT_MERGE, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0);
      send_item(ACT_MERGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
      send_item(ACT_CHECK, 32'h0000_0000, 32'h1234_5678, 1'b1, 1'b1);
      send_item(ACT_CHECK, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0);
      send_item(ACT_MERGE, 32'h5A5A_A5A5, 32'hA5A5_5A5A, 1'b1, 1'b0);
      send_item(ACT_MERGE, 32'h5A5A_A5A5, 32'h0F0F_F0F0, 1'b0, 1'b1);
      send_item(ACT_CHECK, 32'h5A5A_A5A5, 32'h0000_0000, 1'b0, 1'b0);
      send_item(ACT_MERGE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0);
      send_item(ACT_MERGE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b1);
      send_item(ACT_CHECK, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0);
      send_item(ACT_MERGE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0);
      send_item(ACT_CHECK, 32'hA5A5_5A5A, 32'hFFFF_FFFF, 1'b1, 1'b1);
   endtask

   task automatic test_random_traffic(int count);
      repeat (count) send_random_item();
   endtask

   task automatic test_table_full();
      int free_count;
      logic [31:0] kept_id;
      do begin
         send_item(ACT_MERGE, $urandom, $urandom, 1'($urandom_range(1)),
                   1'($urandom_range(1)));
         free_count = 0;
         for (int i = 0; i < DEPTH; i++) begin
            if (!tbl_valid[i]) free_count++;
         end
      end while (free_count > 0);
      kept_id = tbl_app[$urandom_range(DEPTH - 1)];
      repeat (3) send_item(ACT_MERGE, $urandom, $urandom, 1'b1, 1'b1);
      send_item(ACT_CHECK, $urandom, 32'h0000_0000, 1'b0, 1'b0);
      send_item(ACT_MERGE, kept_id, 32'hDEAD_BEEF, 1'b1, 1'b1);
      send_item(ACT_CHECK, kept_id, 32'h0000_0000, 1'b0, 1'b0);
   endtask

   task automatic test_back_to_back(int count);
      no_idle = 1;
      repeat (count) send_random_item();
      no_idle = 0;
   endtask

   task automatic test_result_backpressure(int count);
      hold_rsp = 1;
      repeat (count) send_random_item();
   endtask

   initial begin
      id_pool[0] = 32'h0000_0000;
      id_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < POOL_SIZE; i++) begin
         id_pool[i] = $urandom;
      end
      for (int i = 0; i < DEPTH; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_app[i] = '0;
         tbl_vendor[i] = '0;
         tbl_auth[i] = 1'b0;
         tbl_acct[i] = 1'b0;
      end
      @(negedge reset);
      test_empty_lookup();
      test_insert_and_merge();
      test_random_traffic(300);
      test_table_full();
      test_back_to_back(100);
      test_result_backpressure(30);
      test_random_traffic(250);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
